// ===== sv/wmps_pkg.sv =====
`default_nettype none
package wmps_pkg;

  localparam int Slots      = 64;
  localparam int IdxBits    = $clog2(Slots);
  localparam int SlotBits   = 6;
  localparam int PassBits   = 48;
  localparam int WeightBits = 16;
  localparam int ChanBits   = 16;
  localparam int TsBits     = 32;
  localparam int CfgBits    = 32;
  localparam int OutPass    = 48;
  localparam int InBits     = 48;
  localparam int OutBits    = 56;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_WAKE  = 3'd1,
    OP_READY = 3'd2,
    OP_PICK  = 3'd3,
    OP_FIN   = 3'd4,
    OP_REL   = 3'd5,
    OP_SETW  = 3'd6,
    OP_NOP   = 3'd7
  } op_e;

  // slot lifecycle codes
  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_ALLOC    = 3'd1;
  localparam logic [2:0] ST_SLEEP    = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] ST_EXITED   = 3'd5;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  localparam logic [1:0] END_RUNNABLE = 2'd0;
  localparam logic [1:0] END_SLEEP    = 2'd1;

  localparam logic CFG_QUANTUM   = 1'b0;
  localparam logic CFG_START_MIN = 1'b1;

  typedef struct packed {
    logic [2:0]            st;
    logic [PassBits-1:0]   pass;
    logic [WeightBits-1:0] w;
    logic [ChanBits-1:0]   chan;
  } entry_t;

  localparam int EntryBits = $bits(entry_t);

  typedef struct packed {
    logic latch;
    logic rd_tgt;
    logic chk;
    logic div_init;
    logic div_step;
    logic fin_wr;
    logic rd_idx;
    logic eval;
    logic pick_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic chk_ok;
    logic div_done;
    logic idx_last;
    logic hit;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/wmps_ram.sv =====
`default_nettype none
module wmps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/wmps_dp.sv =====
`default_nettype none
module wmps_dp
  import wmps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [CfgBits-1:0]  cfg_data_i,
  input  wire logic [2:0]          op_i,
  input  wire logic [SlotBits-1:0] slot_i,
  input  wire logic [ChanBits-1:0] chan_i,
  input  wire logic [1:0]          end_i,
  input  wire logic [WeightBits-1:0] nw_i,
  output logic [SlotBits-1:0]      res_slot_o,
  output logic [1:0]               res_status_o,
  output logic [OutPass-1:0]       res_pass_o
);

  op_e                   op_q;
  logic [SlotBits-1:0]   slot_q;
  logic [ChanBits-1:0]   chan_q;
  logic [1:0]            end_q;
  logic [WeightBits-1:0] nw_q;
  logic [TsBits-1:0]     ts_q;
  logic [PassBits-1:0]   min_q;
  logic [WeightBits-1:0] wcnt_q;
  logic [Slots-1:0]      valid_q;
  logic [IdxBits-1:0]    idx_q, rd_addr_q;
  logic                  found_q, err_q;
  logic [IdxBits-1:0]    best_idx_q;
  entry_t                best_q, tgt_q;
  logic [TsBits-1:0]     quo_q;
  logic [WeightBits-1:0] rem_q, den_q;
  logic [4:0]            dcnt_q;

  logic [EntryBits-1:0]  ram_rdata, ram_wdata;
  logic                  ram_we;
  logic [IdxBits-1:0]    ram_waddr, ram_raddr;
  entry_t                rd_ent, wr_ent;
  logic                  rd_valid, slot_ok, chk_ok, wake_hit;
  logic [IdxBits-1:0]    tgt_idx;
  logic [WeightBits:0]   trial;
  logic                  trial_ge;
  logic [PassBits:0]     fin_sum;
  logic [WeightBits-1:0] wcnt_inc;

  assign tgt_idx   = slot_q[IdxBits-1:0];
  assign ram_raddr = cmd_i.rd_tgt ? tgt_idx : idx_q;
  assign rd_valid  = valid_q[rd_addr_q];
  assign rd_ent    = rd_valid ? entry_t'(ram_rdata) : '0;
  assign slot_ok   = {1'b0, slot_q} < (SlotBits+1)'(Slots);
  assign wake_hit  = rd_valid && (rd_ent.st == ST_SLEEP) && (rd_ent.chan == chan_q);

  wmps_ram #(.Width(EntryBits), .Depth(Slots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // check of the target slot
  always_comb begin
    chk_ok = 1'b0;
    unique case (op_q)
      OP_READY: chk_ok = (rd_ent.st == ST_ALLOC) || (rd_ent.st == ST_SLEEP) ||
                         (rd_ent.st == ST_RUNNABLE);
      OP_FIN:   chk_ok = (rd_ent.st == ST_RUNNING);
      OP_REL:   chk_ok = rd_valid;
      OP_SETW:  chk_ok = rd_valid && (nw_q != '0);
      default:  chk_ok = 1'b0;
    endcase
    chk_ok = chk_ok && slot_ok;
  end

  // one restoring division step
  assign trial    = {rem_q, quo_q[TsBits-1]};
  assign trial_ge = trial >= {1'b0, den_q};

  // saturating pass charge
  assign fin_sum  = {1'b0, tgt_q.pass} + (PassBits+1)'(quo_q);
  assign wcnt_inc = wcnt_q + 1'b1;

  // select the table write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt_idx;
    wr_ent    = rd_ent;
    if (cmd_i.chk && chk_ok && op_q == OP_READY) begin
      ram_we    = 1'b1;
      wr_ent.st = ST_RUNNABLE;
    end else if (cmd_i.chk && chk_ok && op_q == OP_SETW) begin
      ram_we   = 1'b1;
      wr_ent.w = nw_q;
    end else if (cmd_i.eval && op_q == OP_ALLOC && !rd_valid) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      wr_ent    = '{st: ST_ALLOC, pass: min_q, w: wcnt_q, chan: '0};
    end else if (cmd_i.eval && op_q == OP_WAKE && wake_hit) begin
      ram_we      = 1'b1;
      ram_waddr   = idx_q;
      wr_ent.st   = ST_RUNNABLE;
      wr_ent.pass = min_q;
    end else if (cmd_i.fin_wr) begin
      ram_we = 1'b1;
      wr_ent = tgt_q;
      if (tgt_q.w == '0 || fin_sum[PassBits]) begin
        wr_ent.pass = '1;
      end else begin
        wr_ent.pass = fin_sum[PassBits-1:0];
      end
      priority case (end_q)
        END_RUNNABLE: wr_ent.st = ST_RUNNABLE;
        END_SLEEP: begin
          wr_ent.st   = ST_SLEEP;
          wr_ent.chan = chan_q;
        end
        default: wr_ent.st = ST_EXITED;
      endcase
    end else if (cmd_i.pick_wr && found_q) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_q;
      wr_ent    = best_q;
      wr_ent.st = ST_RUNNING;
    end
  end
  assign ram_wdata = EntryBits'(wr_ent);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_e'(op_i);
      slot_q <= slot_i;
      chan_q <= chan_i;
      end_q  <= end_i;
      nw_q   <= nw_i;
    end
    rd_addr_q <= ram_raddr;
    if (cmd_i.chk) begin
      tgt_q <= rd_ent;
    end
    if (cmd_i.eval && (op_q == OP_PICK || op_q == OP_FIN) && rd_ent.st == ST_RUNNABLE &&
        (!found_q || rd_ent.pass < best_q.pass)) begin
      best_q     <= rd_ent;
      best_idx_q <= idx_q;
    end else if (cmd_i.eval && op_q == OP_ALLOC && !rd_valid && !found_q) begin
      best_idx_q <= idx_q;
    end
    // serial divider
    if (cmd_i.div_init) begin
      quo_q  <= ts_q;
      rem_q  <= '0;
      den_q  <= rd_ent.w;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[TsBits-2:0], trial_ge};
      rem_q  <= trial_ge ? WeightBits'(trial - {1'b0, den_q}) : trial[WeightBits-1:0];
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      res_slot_o <= ((op_q == OP_ALLOC || op_q == OP_PICK) && found_q) ?
                    SlotBits'(best_idx_q) : slot_q;
      if ((op_q == OP_ALLOC || op_q == OP_PICK) && !found_q) begin
        res_status_o <= STAT_NONE;
      end else if (err_q) begin
        res_status_o <= STAT_BAD;
      end else begin
        res_status_o <= STAT_OK;
      end
      res_pass_o <= OutPass'(((op_q == OP_PICK || op_q == OP_FIN) && found_q) ?
                             best_q.pass : min_q);
    end
  end

  // control state of the table and the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q    <= TsBits'(10000000);
      min_q   <= PassBits'(3);
      wcnt_q  <= WeightBits'(1);
      valid_q <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_QUANTUM) begin
        ts_q <= cfg_data_i[TsBits-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_START_MIN) begin
        min_q <= PassBits'(cfg_data_i);
      end else if (cmd_i.out_load && op_q == OP_FIN && found_q) begin
        min_q <= best_q.pass;
      end
      if (cmd_i.latch) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        err_q   <= 1'b0;
      end
      if (cmd_i.chk) begin
        err_q <= !chk_ok;
        if (chk_ok && op_q == OP_REL) begin
          valid_q[tgt_idx] <= 1'b0;
        end
      end
      if (cmd_i.eval) begin
        idx_q <= idx_q + 1'b1;
        if ((op_q == OP_PICK || op_q == OP_FIN) && rd_ent.st == ST_RUNNABLE) begin
          found_q <= 1'b1;
        end
        if (op_q == OP_ALLOC && !rd_valid && !found_q) begin
          found_q        <= 1'b1;
          valid_q[idx_q] <= 1'b1;
          wcnt_q         <= (wcnt_inc == '0) ? WeightBits'(1) : wcnt_inc;
        end
      end
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.chk_ok   = chk_ok;
  assign sts_o.div_done = (dcnt_q == 5'(TsBits-1));
  assign sts_o.idx_last = (idx_q == IdxBits'(Slots-1));
  assign sts_o.hit      = !rd_valid;

endmodule
`default_nettype wire

// ===== sv/wmps_ctrl.sv =====
`default_nettype none
module wmps_ctrl
  import wmps_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_TRD  = 9'b000000010,
    S_TCHK = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_FWR  = 9'b000010000,
    S_SRD  = 9'b000100000,
    S_SEV  = 9'b001000000,
    S_PWR  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // sequence one transaction through the table
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_TRD;
        end
      end
      S_TRD: begin
        // route by the latched op
        priority case (sts_i.op)
          OP_ALLOC, OP_WAKE, OP_PICK: state_d = S_SRD;
          OP_NOP:                     state_d = S_OUT;
          default: begin
            cmd_o.rd_tgt = 1'b1;
            state_d      = S_TCHK;
          end
        endcase
      end
      S_TCHK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.op == OP_FIN && sts_i.chk_ok) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_FWR;
        end
      end
      S_FWR: begin
        cmd_o.fin_wr = 1'b1;
        state_d      = S_SRD;
      end
      S_SRD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = S_SEV;
      end
      S_SEV: begin
        cmd_o.eval = 1'b1;
        if (sts_i.idx_last || (sts_i.op == OP_ALLOC && sts_i.hit)) begin
          state_d = (sts_i.op == OP_PICK) ? S_PWR : S_OUT;
        end else begin
          state_d = S_SRD;
        end
      end
      S_PWR: begin
        cmd_o.pick_wr = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/weighted_min_pass_scheduler_unit.sv =====
// Stride scheduler over 64 task slots, one event per transaction.
// Input stream s_axis carries an event: op, slot, channel, end state and
// new weight. Output stream m_axis carries one result per event: slot,
// status and pass. The config port writes the quantum numerator (index 0)
// or start_min_pass (index 1, also loads the minimum pass at once).
// Events are handled one at a time; s_axis_tready is high only when idle.
// From accept to result: ready, release and set weight read and check the
// target slot; the no-op goes straight to the result. Allocate and wake
// scan the slot table with a read and an evaluate per slot (allocate stops
// at the first free slot); pick scans and then marks its choice running.
// Finish adds a serial divide and a table write before the scan. The block
// returns to idle after each result.
// The table RAM gives one registered read per cycle, which bounds the scan.
// A result sits in an output register; the next event may start while it
// waits, and a stalled receiver blocks the block only when the following
// result is ready to load.
// Reset frees every slot, sets the quantum to 10000000, the minimum pass
// to 3 and the weight counter to 1. No clearing pass is needed.
`default_nettype none
module weighted_min_pass_scheduler_unit
  import wmps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // op[2:0], slot[8:3], channel[24:9], end_state[26:25], new_weight[42:27]
  input  wire logic [InBits-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // result_slot[5:0], status[7:6], result_pass[55:8]
  output logic [OutBits-1:0]      m_axis_tdata,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [CfgBits-1:0] cfg_data_i
);

  cmd_t                cmd;
  sts_t                sts;
  logic [SlotBits-1:0] res_slot;
  logic [1:0]          res_status;
  logic [OutPass-1:0]  res_pass;

  wmps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wmps_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (s_axis_tdata[2:0]),
    .slot_i       (s_axis_tdata[8:3]),
    .chan_i       (s_axis_tdata[24:9]),
    .end_i        (s_axis_tdata[26:25]),
    .nw_i         (s_axis_tdata[42:27]),
    .res_slot_o   (res_slot),
    .res_status_o (res_status),
    .res_pass_o   (res_pass)
  );

  assign m_axis_tdata = {res_pass, res_status, res_slot};

  // a taken transaction closes the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // a new result only appears after the block was busy with its event
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without event");

  // status code three is never produced
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:6] != 2'b11)
    else $error("bad status code");

endmodule
`default_nettype wire
